// ===== rtl/lrup_pkg.sv =====
// shared types, constants and helpers for the lru page replacement block
`timescale 1ns / 1ps
`default_nettype none
package lrup_pkg;

   localparam int FRAMES     = 8;
   localparam int PAGE_BITS  = 16;
   localparam int FRAME_BITS = (FRAMES > 1) ? $clog2(FRAMES) : 1;
   localparam int COUNT_BITS = $clog2(FRAMES + 1);
   localparam int AGE_BITS   = 16;
   localparam int TOTAL_BITS = 32;

   localparam logic [AGE_BITS-1:0]   AGE_MAX   = {AGE_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   // configuration port
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int FC_BITS        = 4;
   localparam logic [0:0] REG_FRAME_COUNT = 1'b0;
   localparam logic [FC_BITS-1:0] FRAME_COUNT_RESET = 4'd4;

   typedef struct packed {
      logic [15:0] page;
      logic        last_ref;
   } req_type;

   typedef struct packed {
      logic        fault;
      logic [2:0]  frame_slot;
      logic [31:0] fault_total;
      logic        final_res;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // clamp the programmed frame count to 1..FRAMES
   function automatic logic [COUNT_BITS-1:0] frames_in_use(input logic [FC_BITS-1:0] fc);
      logic [COUNT_BITS-1:0] n;
      if (fc == '0) begin
         n = COUNT_BITS'(1);
      end else if (32'(fc) > 32'(FRAMES)) begin
         n = COUNT_BITS'(FRAMES);
      end else begin
         n = COUNT_BITS'(fc);
      end
      return n;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/lrup_ram.sv =====
// generic single-port-write, registered-read ram
`timescale 1ns / 1ps
`default_nettype none
module lrup_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  wire logic                                  clock,
   input  wire logic                                  we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                      wdata,
   input  wire logic                                  re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output      logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// top level of the lru page replacement block
//
//   channel | direction | handshake              | beat
//   req     | in        | req_valid / req_stall  | req_data  (page, last_ref)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (fault, frame_slot, fault_total,
//           |           |                        |            final_res)
//   csr     | in        | csr_psel / csr_penable | frame_count at byte addresses 0 to 3
//
// an item is accepted; each filled frame in use is then read from the page and age rams,
// each returned entry is compared and aged, and a write-back step writes back and
// registers the result; with no filled frame in use the scan is skipped
// reset is synchronous: ages read as zero through per-frame valid bits, counts clear at once
// the next request beat is taken while the result beat waits; the write-back stage holds
// only if the previous result beat is still stalled
`timescale 1ns / 1ps
`default_nettype none
module lru_page_replacement (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request channel
   input  wire logic                                  req_valid,
   output      logic                                  req_stall,
   input  wire lrup_pkg::req_type                     req_data,
   // result channel
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_stall,
   output      lrup_pkg::rsp_type                     rsp_data,
   // configuration port
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [lrup_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  wire logic [lrup_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output      logic [lrup_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output      logic                                  csr_pready
);

   localparam int FB = lrup_pkg::FRAME_BITS;
   localparam int CB = lrup_pkg::COUNT_BITS;
   localparam int AB = lrup_pkg::AGE_BITS;
   localparam int PB = lrup_pkg::PAGE_BITS;
   localparam int TB = lrup_pkg::TOTAL_BITS;

   // ---------------------------------------------------------------- configuration
   logic [lrup_pkg::FC_BITS-1:0] frame_count_ff, frame_count_in;
   logic                         csr_wr;
   logic                         csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == lrup_pkg::REG_FRAME_COUNT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      frame_count_in = frame_count_ff;
      if (csr_wr && csr_hit) begin
         frame_count_in = csr_pwdata[lrup_pkg::FC_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_hit) begin
         csr_prdata = lrup_pkg::CSR_DATA_BITS'(frame_count_ff);
      end
   end

   // ---------------------------------------------------------------- state
   lrup_pkg::state_type state_ff, state_in;

   logic [PB-1:0]     page_ff, page_in;        // page under test
   logic              last_ff, last_in;
   logic [CB-1:0]     active_ff, active_in;    // filled frames in use
   logic [CB-1:0]     nuse_ff, nuse_in;        // frames in use
   logic [CB-1:0]     filled_ff, filled_in;
   logic [TB-1:0]     faults_ff, faults_in;
   logic [CB-1:0]     issue_ff, issue_in;      // next frame to read
   logic              rd_vld_ff, rd_vld_in;    // ram data for rd_idx is on the output
   logic [FB-1:0]     rd_idx_ff, rd_idx_in;
   logic              hit_ff, hit_in;
   logic [FB-1:0]     hit_slot_ff, hit_slot_in;
   logic [AB-1:0]     best_age_ff, best_age_in;
   logic [FB-1:0]     best_slot_ff, best_slot_in;
   logic [lrup_pkg::FRAMES-1:0] age_vld_ff, age_vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   lrup_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ram ports
   logic          page_we, age_we, ram_re;
   logic [FB-1:0] page_waddr, age_waddr, ram_raddr;
   logic [PB-1:0] page_wdata, page_rdata;
   logic [AB-1:0] age_wdata, age_rdata;

   lrup_ram #(.WIDTH(PB), .DEPTH(lrup_pkg::FRAMES)) u_page_ram (
      .clock (clock),
      .we    (page_we),
      .waddr (page_waddr),
      .wdata (page_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (page_rdata)
   );

   lrup_ram #(.WIDTH(AB), .DEPTH(lrup_pkg::FRAMES)) u_age_ram (
      .clock (clock),
      .we    (age_we),
      .waddr (age_waddr),
      .wdata (age_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (age_rdata)
   );

   // ---------------------------------------------------------------- handshake
   logic req_take;
   logic rsp_take;
   logic fin_go;

   assign req_stall = (state_ff != lrup_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   // write-back may go once the output register is free or being emptied
   assign fin_go    = (state_ff == lrup_pkg::ST_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // ---------------------------------------------------------------- scan datapath
   logic [CB-1:0] n_now;
   logic [CB-1:0] act_now;
   logic [AB-1:0] cur_age;
   logic [AB-1:0] new_age;
   logic          is_match;
   logic          scan_done;
   logic          miss;
   logic          use_empty;
   logic [FB-1:0] fill_slot;
   logic [TB-1:0] faults_inc;

   assign n_now   = lrup_pkg::frames_in_use(frame_count_ff);
   assign act_now = (filled_ff < n_now) ? filled_ff : n_now;

   // an age entry never written since reset or the last string end reads as zero
   assign cur_age  = age_vld_ff[rd_idx_ff] ? age_rdata : '0;
   assign is_match = rd_vld_ff && !hit_ff && (page_rdata == page_ff);
   always_comb begin
      if (is_match) begin
         new_age = '0;
      end else if (cur_age == lrup_pkg::AGE_MAX) begin
         new_age = cur_age;
      end else begin
         new_age = cur_age + AB'(1);
      end
   end

   // the last read's data is on the ram output once every read has been issued
   assign scan_done = rd_vld_ff && (issue_ff == active_ff);

   assign miss       = !hit_ff;
   assign use_empty  = (active_ff < nuse_ff);
   assign fill_slot  = use_empty ? active_ff[FB-1:0] : best_slot_ff;
   assign faults_inc = (faults_ff == lrup_pkg::TOTAL_MAX) ? faults_ff : faults_ff + TB'(1);

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lrup_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (act_now == '0) ? lrup_pkg::ST_FINISH : lrup_pkg::ST_SCAN;
            end
         end
         lrup_pkg::ST_SCAN: begin
            if (scan_done) begin
               state_in = lrup_pkg::ST_FINISH;
            end
         end
         lrup_pkg::ST_FINISH: begin
            if (fin_go) begin
               state_in = lrup_pkg::ST_IDLE;
            end
         end
         default: state_in = lrup_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath and outputs
   always_comb begin
      page_in      = page_ff;
      last_in      = last_ff;
      active_in    = active_ff;
      nuse_in      = nuse_ff;
      filled_in    = filled_ff;
      faults_in    = faults_ff;
      issue_in     = issue_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      best_age_in  = best_age_ff;
      best_slot_in = best_slot_ff;
      age_vld_in   = age_vld_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_take;
      rsp_data_in  = rsp_data_ff;

      ram_re     = 1'b0;
      ram_raddr  = issue_ff[FB-1:0];
      page_we    = 1'b0;
      page_waddr = fill_slot;
      page_wdata = page_ff;
      age_we     = 1'b0;
      age_waddr  = rd_idx_ff;
      age_wdata  = new_age;

      unique case (state_ff)
         lrup_pkg::ST_IDLE: begin
            if (req_take) begin
               page_in      = PB'(req_data.page);
               last_in      = req_data.last_ref;
               active_in    = act_now;
               nuse_in      = n_now;
               issue_in     = '0;
               hit_in       = 1'b0;
               hit_slot_in  = '0;
               best_age_in  = '0;
               best_slot_in = '0;
            end
         end
         lrup_pkg::ST_SCAN: begin
            // issue one read per cycle
            if (issue_ff < active_ff) begin
               ram_re    = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[FB-1:0];
               issue_in  = issue_ff + CB'(1);
            end
            // compare, age and track the oldest on the returned entry
            if (rd_vld_ff) begin
               age_we                = 1'b1;
               age_vld_in[rd_idx_ff] = 1'b1;
               if (is_match) begin
                  hit_in      = 1'b1;
                  hit_slot_in = rd_idx_ff;
               end else if (new_age > best_age_ff) begin
                  best_age_in  = new_age;
                  best_slot_in = rd_idx_ff;
               end
            end
         end
         lrup_pkg::ST_FINISH: begin
            if (fin_go) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.fault     = miss;
               rsp_data_in.final_res = last_ff;
               if (miss) begin
                  page_we                 = 1'b1;
                  age_we                  = 1'b1;
                  age_waddr               = fill_slot;
                  age_wdata               = '0;
                  age_vld_in[fill_slot]   = 1'b1;
                  faults_in               = faults_inc;
                  rsp_data_in.frame_slot  = 3'(fill_slot);
                  rsp_data_in.fault_total = 32'(faults_inc);
                  if (use_empty) begin
                     filled_in = active_ff + CB'(1);
                  end
               end else begin
                  rsp_data_in.frame_slot  = 3'(hit_slot_ff);
                  rsp_data_in.fault_total = 32'(faults_ff);
               end
               // end of reference string: ages, fill count and total start afresh
               if (last_ff) begin
                  age_vld_in = '0;
                  filled_in  = '0;
                  faults_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= lrup_pkg::ST_IDLE;
         frame_count_ff <= lrup_pkg::FRAME_COUNT_RESET;
         filled_ff      <= '0;
         faults_ff      <= '0;
         age_vld_ff     <= '0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         issue_ff       <= '0;
         hit_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frame_count_ff <= frame_count_in;
         filled_ff      <= filled_in;
         faults_ff      <= faults_in;
         age_vld_ff     <= age_vld_in;
         rd_vld_ff      <= rd_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         issue_ff       <= issue_in;
         hit_ff         <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff      <= page_in;
      last_ff      <= last_in;
      active_ff    <= active_in;
      nuse_ff      <= nuse_in;
      rd_idx_ff    <= rd_idx_in;
      hit_slot_ff  <= hit_slot_in;
      best_age_ff  <= best_age_in;
      best_slot_ff <= best_slot_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_filled_range: assert property (@(posedge clock) disable iff (reset)
      32'(filled_ff) <= lrup_pkg::FRAMES)
      else $error("fill count beyond frame count");

   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lrup_pkg::ST_SCAN) |-> (issue_ff <= active_ff))
      else $error("frame scan ran past the filled frames");

   a_finish_result: assert property (@(posedge clock) disable iff (reset)
      fin_go |=> (rsp_valid_ff && (state_ff == lrup_pkg::ST_IDLE)))
      else $error("write-back did not register a result");

   a_hit_no_count: assert property (@(posedge clock) disable iff (reset)
      (fin_go && hit_ff && !last_ff) |=> $stable(faults_ff) && $stable(filled_ff))
      else $error("hit changed fault total or fill count");
`endif

endmodule
`default_nettype wire
